@@ src/gas_pkg.sv @@
`default_nettype none
package gas_pkg;

   // field widths
   localparam int CoordW  = 32;
   localparam int WeightW = 32;
   localparam int BandW   = 31;
   localparam int GapW    = CoordW + 1;
   localparam int SumW    = 66;
   localparam int RootW   = 35;
   localparam int AccW    = 96;
   localparam int OpbW    = 64;
   localparam int CntW    = 7;
   localparam int CsrIdxW = 2;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegOwnWeight = 2'd0;
   localparam logic [CsrIdxW-1:0] RegGravScale = 2'd1;
   localparam logic [CsrIdxW-1:0] RegDeadBand  = 2'd2;

   // register reset values
   localparam logic [WeightW-1:0] OwnWeightRst = 32'h0001_0000;
   localparam logic [WeightW-1:0] GravScaleRst = 32'h0001_0000;
   localparam logic [BandW-1:0]   DeadBandRst  = 31'd655;

   // step counts for the shared unit
   localparam logic [CntW-1:0] StepsSquare = 7'd33;
   localparam logic [CntW-1:0] StepsSqrt   = 7'd35;
   localparam logic [CntW-1:0] StepsMul32  = 7'd32;
   localparam logic [CntW-1:0] StepsMulV   = 7'd17;
   localparam logic [CntW-1:0] StepsDivU   = 7'd49;
   localparam logic [CntW-1:0] StepsDivW   = 7'd80;
   localparam logic [CntW-1:0] StepsDivD   = 7'd96;

   // movement cap, 2^34
   localparam logic [RootW-1:0] MoveCap = 35'h4_0000_0000;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ISSUE,
      ST_WAIT,
      ST_APPLY,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      PH_SQ0,
      PH_SQ1,
      PH_SQ2,
      PH_SQRT,
      PH_MULM,
      PH_MULF,
      PH_DIVU,
      PH_MULV,
      PH_DIVW,
      PH_DIVD
   } phase_type;

   typedef struct packed {
      logic            start;
      op_type          op;
      logic [AccW-1:0] opa;
      logic [OpbW-1:0] opb;
      logic [CntW-1:0] steps;
   } unit_req_type;

   typedef struct packed {
      logic            done;
      logic [AccW-1:0] result;
   } unit_rsp_type;

   // magnitude of the gap between two coordinates
   function automatic logic [GapW-1:0] abs_gap(input logic [CoordW-1:0] o,
                                                input logic [CoordW-1:0] p);
      logic [GapW-1:0] g;
      begin
         g = {o[CoordW-1], o} - {p[CoordW-1], p};
         abs_gap = g[GapW-1] ? (~g + 33'd1) : g;
      end
   endfunction

endpackage
`default_nettype wire

@@ src/gas_if.sv @@
`default_nettype none
interface gas_req_if;
   import gas_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic signed [CoordW-1:0]  in_x;
   logic signed [CoordW-1:0]  in_y;
   logic signed [CoordW-1:0]  in_z;
   logic        [WeightW-1:0] other_weight;
   modport source (output valid, mode, in_x, in_y, in_z, other_weight, input ready);
   modport sink (input valid, mode, in_x, in_y, in_z, other_weight, output ready);
endinterface

interface gas_rsp_if;
   import gas_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] pos_x;
   logic signed [CoordW-1:0] pos_y;
   logic signed [CoordW-1:0] pos_z;
   logic                     clipped;
   modport source (output valid, pos_x, pos_y, pos_z, clipped, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, clipped, output ready);
endinterface

interface gas_csr_if;
   import gas_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CsrIdxW-1:0]    index;
   logic [WeightW-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/gas_unit.sv @@
`default_nettype none
module gas_unit import gas_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire unit_req_type ureq,
   output unit_rsp_type      ursp
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   op_type          op_ff, op_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [AccW-1:0] acc_ff, acc_in;
   logic [AccW-1:0] mc_ff, mc_in;
   logic [OpbW-1:0] mp_ff, mp_in;
   logic [RootW:0]  rem_ff, rem_in;
   logic [RootW-1:0] root_ff, root_in;
   logic [RootW-1:0] div_ff, div_in;

   logic [RootW:0]   div_sh;
   logic             div_ge;
   logic [RootW+2:0] sq_sh;
   logic [RootW+2:0] sq_trial;
   logic [RootW+2:0] sq_diff;
   logic             sq_ge;

   // one step of multiply, divide or square root
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      div_in  = div_ff;

      div_sh   = {rem_ff[RootW-1:0], acc_ff[AccW-1]};
      div_ge   = div_sh >= {1'b0, div_ff};
      sq_sh    = {rem_ff, acc_ff[AccW-1 -: 2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      sq_diff  = sq_sh - sq_trial;
      sq_ge    = sq_sh >= sq_trial;

      if (ureq.start) begin
         busy_in = 1'b1;
         op_in   = ureq.op;
         cnt_in  = ureq.steps;
         rem_in  = '0;
         root_in = '0;
         div_in  = ureq.opb[RootW-1:0];
         mc_in   = ureq.opa;
         mp_in   = ureq.opb;
         acc_in  = (ureq.op == OP_MUL) ? '0 : ureq.opa;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         case (op_ff)
            OP_MUL: begin
               acc_in = mp_ff[0] ? (acc_ff + mc_ff) : acc_ff;
               mc_in  = {mc_ff[AccW-2:0], 1'b0};
               mp_in  = {1'b0, mp_ff[OpbW-1:1]};
            end
            OP_DIV: begin
               rem_in = div_ge ? (div_sh - {1'b0, div_ff}) : div_sh;
               acc_in = {acc_ff[AccW-2:0], div_ge};
            end
            OP_SQRT: begin
               // remainder never exceeds twice the root
               rem_in  = sq_ge ? sq_diff[RootW:0] : sq_sh[RootW:0];
               root_in = {root_ff[RootW-2:0], sq_ge};
               acc_in  = {acc_ff[AccW-3:0], 2'b00};
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      mc_ff   <= mc_in;
      mp_ff   <= mp_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
   end

   // result selection
   always_comb begin
      ursp.done   = done_ff;
      ursp.result = (op_ff == OP_SQRT) ? {{(AccW-RootW){1'b0}}, root_ff} : acc_ff;
   end

endmodule
`default_nettype wire

@@ src/gravity_attraction_step_core.sv @@
`default_nettype none
// channel   | dir | handshake     | beat contents
// req_chan  | in  | valid / ready | mode, in_x, in_y, in_z, other_weight
// rsp_chan  | out | valid / ready | pos_x, pos_y, pos_z, clipped
// csr_chan  | in  | valid / ready | index, data (always ready)
//
// a load item only sets the position; an attract item runs each axis outside
// the deadband through the one shared shift-add multiply / restoring divide / square root
// unit, which runs one bit (two for the root) per cycle. an axis inside the deadband is
// skipped. reset is synchronous, clears position and control and sets the registers
// to their reset values. a stalled result holds the block before idle.
module gravity_attraction_step_core import gas_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   gas_req_if.sink   req_chan,
   gas_rsp_if.source rsp_chan,
   gas_csr_if.sink   csr_chan
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [1:0] axis_ff, axis_in;
   logic [CoordW-1:0] pos_ff [3];
   logic [CoordW-1:0] pos_in [3];
   logic [CoordW-1:0] oth_ff [3];
   logic [CoordW-1:0] oth_in [3];
   logic [WeightW-1:0] ow_ff, ow_in;
   logic clip_ff, clip_in;
   logic [SumW-1:0]  s_ff, s_in;
   logic [RootW-1:0] r_ff, r_in;
   logic [47:0] m_ff, m_in;
   logic [63:0] f_ff, f_in;
   logic [16:0] u_ff, u_in;
   logic [63:0] v_ff, v_in;
   logic [79:0] w_ff, w_in;
   logic [RootW-1:0] d_ff, d_in;

   logic [WeightW-1:0] own_weight_ff;
   logic [WeightW-1:0] grav_scale_ff;
   logic [BandW-1:0]   dead_band_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [CoordW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic rsp_clip_ff;
   logic rsp_load;

   unit_req_type ureq;
   unit_rsp_type ursp;

   logic [GapW-1:0] gap_abs [3];
   logic [GapW-1:0] a_cur;
   logic [GapW-1:0] sq_op;
   logic            gap_up;
   logic [GapW-1:0] gap_raw;
   logic [CoordW+3:0] moved;
   logic            big;

   gas_unit u_unit (
      .clock (clock),
      .reset (reset),
      .ureq  (ureq),
      .ursp  (ursp)
   );

   // gaps against the position as it stands now
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         gap_abs[i] = abs_gap(oth_ff[i], pos_ff[i]);
      end
      a_cur   = gap_abs[axis_ff];
      gap_raw = {oth_ff[axis_ff][CoordW-1], oth_ff[axis_ff]}
              - {pos_ff[axis_ff][CoordW-1], pos_ff[axis_ff]};
      gap_up  = !gap_raw[GapW-1] && (gap_raw != '0);
      priority case (phase_ff)
         PH_SQ0:  sq_op = gap_abs[0];
         PH_SQ1:  sq_op = gap_abs[1];
         default: sq_op = gap_abs[2];
      endcase
      big   = (ursp.result[AccW-1:RootW] != '0) || (ursp.result[RootW-1:0] > MoveCap);
      moved = gap_up ? ({{4{pos_ff[axis_ff][CoordW-1]}}, pos_ff[axis_ff]} + {1'b0, d_ff})
                     : ({{4{pos_ff[axis_ff][CoordW-1]}}, pos_ff[axis_ff]} - {1'b0, d_ff});
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      axis_in  = axis_ff;
      pos_in   = pos_ff;
      oth_in   = oth_ff;
      ow_in    = ow_ff;
      clip_in  = clip_ff;
      s_in     = s_ff;
      r_in     = r_ff;
      m_in     = m_ff;
      f_in     = f_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      d_in     = d_ff;
      rsp_load = 1'b0;
      req_chan.ready = 1'b0;
      ureq = '{start: 1'b0, op: OP_MUL, opa: '0, opb: '0, steps: '0};

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               oth_in[0] = req_chan.in_x;
               oth_in[1] = req_chan.in_y;
               oth_in[2] = req_chan.in_z;
               ow_in     = req_chan.other_weight;
               clip_in   = 1'b0;
               axis_in   = 2'd0;
               if (!req_chan.mode) begin
                  pos_in[0] = req_chan.in_x;
                  pos_in[1] = req_chan.in_y;
                  pos_in[2] = req_chan.in_z;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (a_cur < {2'b00, dead_band_ff}) begin
               if (axis_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               s_in     = '0;
               phase_in = PH_SQ0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            ureq.start = 1'b1;
            state_in   = ST_WAIT;
            unique case (phase_ff)
               PH_SQ0, PH_SQ1, PH_SQ2: begin
                  ureq.op    = OP_MUL;
                  ureq.opa   = {{(AccW-GapW){1'b0}}, sq_op};
                  ureq.opb   = {{(OpbW-GapW){1'b0}}, sq_op};
                  ureq.steps = StepsSquare;
               end
               PH_SQRT: begin
                  ureq.op    = OP_SQRT;
                  ureq.opa   = {4'b0000, s_ff, 26'd0};
                  ureq.steps = StepsSqrt;
               end
               PH_MULM: begin
                  ureq.opa   = {64'd0, own_weight_ff};
                  ureq.opb   = {32'd0, ow_ff};
                  ureq.steps = StepsMul32;
               end
               PH_MULF: begin
                  ureq.opa   = {48'd0, m_ff};
                  ureq.opb   = {32'd0, grav_scale_ff};
                  ureq.steps = StepsMul32;
               end
               PH_DIVU: begin
                  ureq.op    = OP_DIV;
                  ureq.opa   = {a_cur, 63'd0};
                  ureq.opb   = {{(OpbW-RootW){1'b0}}, r_ff};
                  ureq.steps = StepsDivU;
               end
               PH_MULV: begin
                  ureq.opa   = {32'd0, f_ff};
                  ureq.opb   = {47'd0, u_ff};
                  ureq.steps = StepsMulV;
               end
               PH_DIVW: begin
                  ureq.op    = OP_DIV;
                  ureq.opa   = {v_ff, 32'd0};
                  ureq.opb   = {{(OpbW-RootW){1'b0}}, r_ff};
                  ureq.steps = StepsDivW;
               end
               PH_DIVD: begin
                  ureq.op    = OP_DIV;
                  ureq.opa   = {w_ff, 16'd0};
                  ureq.opb   = {{(OpbW-RootW){1'b0}}, r_ff};
                  ureq.steps = StepsDivD;
               end
               default: begin
                  ureq.start = 1'b0;
                  state_in   = ST_DONE;
               end
            endcase
         end
         ST_WAIT: begin
            if (ursp.done) begin
               state_in = ST_ISSUE;
               unique case (phase_ff)
                  PH_SQ0: begin
                     s_in     = s_ff + ursp.result[SumW-1:0];
                     phase_in = PH_SQ1;
                  end
                  PH_SQ1: begin
                     s_in     = s_ff + ursp.result[SumW-1:0];
                     phase_in = PH_SQ2;
                  end
                  PH_SQ2: begin
                     s_in     = s_ff + ursp.result[SumW-1:0];
                     phase_in = PH_SQRT;
                  end
                  PH_SQRT: begin
                     r_in     = ursp.result[RootW-1:0];
                     phase_in = PH_MULM;
                     // zero distance leaves the axis alone
                     if (ursp.result[RootW-1:0] == '0) begin
                        if (axis_ff == 2'd2) begin
                           state_in = ST_DONE;
                        end else begin
                           axis_in  = axis_ff + 2'd1;
                           state_in = ST_CHECK;
                        end
                     end
                  end
                  PH_MULM: begin
                     m_in     = ursp.result[63:16];
                     phase_in = PH_MULF;
                  end
                  PH_MULF: begin
                     f_in     = ursp.result[79:16];
                     phase_in = PH_DIVU;
                  end
                  PH_DIVU: begin
                     u_in     = ursp.result[16:0];
                     phase_in = PH_MULV;
                  end
                  PH_MULV: begin
                     v_in     = ursp.result[79:16];
                     phase_in = PH_DIVW;
                  end
                  PH_DIVW: begin
                     w_in     = ursp.result[79:0];
                     phase_in = PH_DIVD;
                  end
                  PH_DIVD: begin
                     d_in     = big ? MoveCap : ursp.result[RootW-1:0];
                     state_in = ST_APPLY;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_APPLY: begin
            // saturate to the signed 32-bit range
            if (!moved[CoordW+3] && (moved[CoordW+2:CoordW-1] != 4'h0)) begin
               pos_in[axis_ff] = 32'h7FFF_FFFF;
               clip_in         = 1'b1;
            end else if (moved[CoordW+3] && (moved[CoordW+2:CoordW-1] != 4'hF)) begin
               pos_in[axis_ff] = 32'h8000_0000;
               clip_in         = 1'b1;
            end else begin
               pos_in[axis_ff] = moved[CoordW-1:0];
            end
            if (axis_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_SQ0;
         axis_ff  <= 2'd0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         axis_ff  <= axis_in;
         pos_ff   <= pos_in;
      end
      oth_ff  <= oth_in;
      ow_ff   <= ow_in;
      clip_ff <= clip_in;
      s_ff    <= s_in;
      r_ff    <= r_in;
      m_ff    <= m_in;
      f_ff    <= f_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      w_ff    <= w_in;
      d_ff    <= d_in;
   end

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_weight_ff <= OwnWeightRst;
         grav_scale_ff <= GravScaleRst;
         dead_band_ff  <= DeadBandRst;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == RegOwnWeight) begin
            own_weight_ff <= csr_chan.data;
         end
         if (csr_chan.index == RegGravScale) begin
            grav_scale_ff <= csr_chan.data;
         end
         if (csr_chan.index == RegDeadBand) begin
            dead_band_ff <= csr_chan.data[BandW-1:0];
         end
      end
   end

   // output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_x_ff    <= pos_ff[0];
         rsp_y_ff    <= pos_ff[1];
         rsp_z_ff    <= pos_ff[2];
         rsp_clip_ff <= clip_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.pos_x   = rsp_x_ff;
   assign rsp_chan.pos_y   = rsp_y_ff;
   assign rsp_chan.pos_z   = rsp_z_ff;
   assign rsp_chan.clipped = rsp_clip_ff;

endmodule
`default_nettype wire

@@ src/gas_checker.sv @@
`default_nettype none
module gas_checker import gas_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [CoordW-1:0] pos_x,
   input wire logic [CoordW-1:0] pos_y,
   input wire logic [CoordW-1:0] pos_z,
   input wire logic              clipped
);

   // a pending result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pos_x) && $stable(pos_y) && $stable(pos_z)
                                  && $stable(clipped))
      else $error("result payload changed while stalled");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in progress");

   // a clipped step leaves some coordinate at a limit
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clipped |->
         pos_x == 32'h7FFF_FFFF || pos_x == 32'h8000_0000 ||
         pos_y == 32'h7FFF_FFFF || pos_y == 32'h8000_0000 ||
         pos_z == 32'h7FFF_FFFF || pos_z == 32'h8000_0000)
      else $error("clipped flag without a saturated coordinate");

endmodule

bind gravity_attraction_step_core gas_checker u_gas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .pos_x     (rsp_chan.pos_x),
   .pos_y     (rsp_chan.pos_y),
   .pos_z     (rsp_chan.pos_z),
   .clipped   (rsp_chan.clipped)
);
`default_nettype wire

@@ dv/tb_gravity_attraction_step_core.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_gravity_attraction_step_core;
   import gas_pkg::*;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic               clip;
   } position_type;

   logic clock;
   logic reset;

   gas_req_if req_chan ();
   gas_rsp_if rsp_chan ();
   gas_csr_if csr_chan ();

   gravity_attraction_step_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // predictor copies of registers and position
   logic [31:0]        mdl_own_weight;
   logic [31:0]        mdl_grav_scale;
   logic [30:0]        mdl_dead_band;
   logic signed [63:0] mdl_pos [3];

   position_type expected_positions[$];
   int  error_count;
   int  result_count;
   int  clip_count;
   int  stall_left;
   bit  idle_enabled;

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run limit
   initial begin
      #400ms;
      $display("Verification failed");
      $finish;
   end

   // integer square root, floor
   function automatic logic [63:0] isqrt(input logic [127:0] s);
      logic [63:0]  res;
      logic [63:0]  c;
      logic [127:0] cc;
      begin
         res = 0;
         for (int b = 34; b >= 0; b--) begin
            c  = res | (64'd1 << b);
            cc = c * c;
            if (cc <= s) res = c;
         end
         return res;
      end
   endfunction

   // move one axis toward the other body; returns 1 on saturation
   function automatic bit move_one_axis(input logic signed [63:0] oth[3], input int k,
                                        input logic [31:0] ow);
      logic signed [63:0] gap;
      logic signed [63:0] e;
      logic signed [63:0] n;
      logic [63:0]        a;
      logic [127:0]       s;
      logic [63:0]        r;
      logic [127:0]       m;
      logic [127:0]       f;
      logic [127:0]       u;
      logic [127:0]       v;
      logic [127:0]       w;
      logic [127:0]       d;
      begin
         gap = oth[k] - mdl_pos[k];
         a   = gap < 0 ? -gap : gap;
         if (a < {33'd0, mdl_dead_band}) return 0;
         s = 0;
         for (int i = 0; i < 3; i++) begin
            e = oth[i] - mdl_pos[i];
            if (e < 0) e = -e;
            s = s + 128'(e) * 128'(e);
         end
         r = isqrt(s);
         if (r == 0) return 0;
         m = (128'(mdl_own_weight) * 128'(ow)) >> 16;
         f = ((m * 128'(mdl_grav_scale)) >> 16) & {64'd0, {64{1'b1}}};
         u = (128'(a) << 16) / 128'(r);
         v = ((f * u) >> 16) & {64'd0, {64{1'b1}}};
         w = (v << 16) / 128'(r);
         d = (w << 16) / 128'(r);
         if (d > 128'(MoveCap)) d = 128'(MoveCap);
         n = gap > 0 ? mdl_pos[k] + 64'(d) : mdl_pos[k] - 64'(d);
         if (n > 64'sd2147483647) begin
            mdl_pos[k] = 64'sd2147483647;
            return 1;
         end
         if (n < -64'sd2147483648) begin
            mdl_pos[k] = -64'sd2147483648;
            return 1;
         end
         mdl_pos[k] = n;
         return 0;
      end
   endfunction

   // expected position after one item
   function automatic position_type predict_position(input bit mode, input logic [31:0] x,
                                                     input logic [31:0] y,
                                                     input logic [31:0] z,
                                                     input logic [31:0] ow);
      logic signed [63:0] oth[3];
      position_type       p;
      bit                 clip;
      begin
         oth[0] = 64'(signed'(x));
         oth[1] = 64'(signed'(y));
         oth[2] = 64'(signed'(z));
         clip = 0;
         if (!mode) begin
            for (int i = 0; i < 3; i++) mdl_pos[i] = oth[i];
         end else begin
            for (int k = 0; k < 3; k++)
               if (move_one_axis(oth, k, ow)) clip = 1;
         end
         p.px = mdl_pos[0][31:0];
         p.py = mdl_pos[1][31:0];
         p.pz = mdl_pos[2][31:0];
         p.clip = clip;
         return p;
      end
   endfunction

   // random idle burst
   task automatic idle_burst();
      if (idle_enabled && $urandom_range(3) == 0)
         repeat ($urandom_range(11, 1)) @(posedge clock);
   endtask

   // send one beat
   task automatic send_item(input bit mode, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] ow);
      idle_burst();
      expected_positions.push_back(predict_position(mode, x, y, z, ow));
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= mode;
      req_chan.in_x         <= x;
      req_chan.in_y         <= y;
      req_chan.in_z         <= z;
      req_chan.other_weight <= ow;
      do @(posedge clock); while (!req_chan.ready);
      req_chan.valid <= 1'b0;
      // the block is busy right after it takes a beat
      @(posedge clock);
   endtask

   // register write while idle
   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [31:0] value);
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (idx)
         RegOwnWeight: mdl_own_weight = value;
         RegGravScale: mdl_grav_scale = value;
         RegDeadBand:  mdl_dead_band  = value[30:0];
         default: ;
      endcase
   endtask

   // result checker and sink stalls
   always @(posedge clock) begin
      position_type exp_pos;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_positions.size() == 0) begin
               $display("%t: unexpected result %h %h %h %b", $realtime, rsp_chan.pos_x,
                        rsp_chan.pos_y, rsp_chan.pos_z, rsp_chan.clipped);
               error_count++;
            end else begin
               exp_pos = expected_positions.pop_front();
               result_count++;
               if (exp_pos.clip) clip_count++;
               if (rsp_chan.pos_x !== exp_pos.px)
                  $display("%t: pos_x expected %h actual %h", $realtime, exp_pos.px,
                           rsp_chan.pos_x);
               if (rsp_chan.pos_y !== exp_pos.py)
                  $display("%t: pos_y expected %h actual %h", $realtime, exp_pos.py,
                           rsp_chan.pos_y);
               if (rsp_chan.pos_z !== exp_pos.pz)
                  $display("%t: pos_z expected %h actual %h", $realtime, exp_pos.pz,
                           rsp_chan.pos_z);
               if (rsp_chan.clipped !== exp_pos.clip)
                  $display("%t: clipped expected %b actual %b", $realtime, exp_pos.clip,
                           rsp_chan.clipped);
               if (rsp_chan.pos_x !== exp_pos.px || rsp_chan.pos_y !== exp_pos.py ||
                   rsp_chan.pos_z !== exp_pos.pz || rsp_chan.clipped !== exp_pos.clip)
                  error_count++;
            end
         end
         // random stall bursts on the result sink
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(7) == 0) begin
            stall_left = $urandom_range(10);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // random coordinate, mostly modest
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0:       return $urandom();
         1:       return 32'(signed'($urandom_range(2000000)) - 1000000);
         default: return 32'(signed'($urandom_range(40000000)) - 20000000);
      endcase
   endfunction

   function automatic logic [31:0] rand_weight();
      case ($urandom_range(3))
         0:       return $urandom();
         1:       return $urandom_range(32'h0004_0000);
         default: return $urandom_range(32'h0100_0000);
      endcase
   endfunction

   task automatic test_directed();
      send_item(1'b0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
      send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      send_item(1'b1, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
      send_item(1'b1, 32'd100, 32'd200, 32'd300, 32'h0001_0000);
      send_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
      send_item(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff);
      send_item(1'b0, 32'h7fff_0000, 32'h0, 32'h8000_ffff, 32'h0);
      send_item(1'b1, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'hffff_ffff);
      send_item(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
      write_reg(RegOwnWeight, 32'hffff_ffff);
      write_reg(RegGravScale, 32'hffff_ffff);
      send_item(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0);
      send_item(1'b1, 32'h0002_0000, 32'h0, 32'hffff_0000, 32'hffff_ffff);
      write_reg(RegDeadBand, 32'h0);
      send_item(1'b0, 32'h5, 32'h5, 32'h5, 32'h0);
      send_item(1'b1, 32'h5, 32'h5, 32'h5, 32'h0001_0000);
      send_item(1'b1, 32'h6, 32'h5, 32'h5, 32'h0001_0000);
      write_reg(RegDeadBand, 32'h7fff_ffff);
      send_item(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff);
      write_reg(2'd3, 32'h1234_5678);
      write_reg(RegOwnWeight, 32'h0);
      write_reg(RegGravScale, 32'h0);
      write_reg(RegDeadBand, 32'h0);
      send_item(1'b1, 32'h1234_5678, 32'h9abc_def0, 32'h0, 32'hffff_ffff);
      write_reg(RegOwnWeight, 32'h0001_0000);
      write_reg(RegGravScale, 32'h0001_0000);
      write_reg(RegDeadBand, 32'd655);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 250 == 125) begin
            write_reg(RegOwnWeight, rand_weight());
            write_reg(RegGravScale, rand_weight());
            write_reg(RegDeadBand, $urandom_range(3) == 0 ? $urandom() : $urandom_range(2000));
         end
         if (i == count - 300) idle_enabled = 0;
         send_item($urandom_range(3) != 0, rand_coord(), rand_coord(), rand_coord(),
                   rand_weight());
      end
   endtask

   initial begin
      reset          = 1'b1;
      idle_enabled   = 1;
      error_count    = 0;
      result_count   = 0;
      clip_count     = 0;
      mdl_own_weight = OwnWeightRst;
      mdl_grav_scale = GravScaleRst;
      mdl_dead_band  = DeadBandRst;
      for (int i = 0; i < 3; i++) mdl_pos[i] = 0;
      req_chan.valid        = 1'b0;
      req_chan.mode         = 1'b0;
      req_chan.in_x         = '0;
      req_chan.in_y         = '0;
      req_chan.in_z         = '0;
      req_chan.other_weight = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = '0;
      csr_chan.data         = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1730);
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("checked %0d positions (%0d saturating) over load and attract beats",
               result_count, clip_count);
      if (error_count == 0 && expected_positions.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
src/gas_pkg.sv
src/gas_if.sv
src/gas_unit.sv
src/gravity_attraction_step_core.sv
src/gas_checker.sv
dv/tb_gravity_attraction_step_core.sv
